### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that simulation builds keep and synthesis builds drop
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication under an active-low reset
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication under an active-low reset
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_SAME(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/lcs_pkg.sv
// ---------------------------------------------------------------------------
// lcs_pkg
// shared sizes, codes and the process table record of the lottery scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TKT_W     = 16 + IDX_W + 1;
  localparam int RND_W     = 31;
  localparam int DCNT_W    = $clog2(RND_W);
  localparam int CLK_W     = 20;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 176;
  localparam int OUT_USER_W = 3;

  localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;

  localparam logic [2:0] EV_CLEARED   = 3'd0;
  localparam logic [2:0] EV_LOADED    = 3'd1;
  localparam logic [2:0] EV_RAN       = 3'd2;
  localparam logic [2:0] EV_COMPLETED = 3'd3;
  localparam logic [2:0] EV_NONE      = 3'd4;

  typedef struct packed {
    logic [15:0]      id;
    logic [15:0]      arrival;
    logic [7:0]       prio;
    logic [15:0]      burst;
    logic [15:0]      remaining;
    logic [TKT_W-1:0] tlow;
    logic [CLK_W-1:0] resp;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/lottery_cpu_scheduler.sv
// ---------------------------------------------------------------------------
// lottery_cpu_scheduler
// lottery cpu scheduler with its process table in one synchronous memory
// ---------------------------------------------------------------------------
// Clear and load items go from the operation state straight to the output stage. A
// draw runs the bit-serial remainder unit over the random word, then walks the
// table entries in the ticket search; the first draw after loading also orders
// the table in memory first (insertion sorts, with each compare and swap going
// through the single read port, then tickets handed out entry by entry). One
// item is worked on at a time; the input is taken again as soon as its result
// sits in the output register.
`default_nettype none

module lottery_cpu_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // proc_id, arrival, prio, burst, random_word
  input  wire logic [lcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic [lcs_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // winner_id, time_now, response, waiting, turnaround, all_done,
  // total_waiting, total_turnaround, total_response
  output logic [lcs_pkg::OUT_DATA_W-1:0]      out_tdata,
  // event_res
  output logic [lcs_pkg::OUT_USER_W-1:0]      out_tuser
);
  import lcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OP, S_SNEXT, S_SRA, S_SRB, S_SCMP, S_SWA, S_SWB,
    S_TRD, S_TWR, S_DIV, S_QRD, S_QCHK, S_APPLY, S_EMIT
  } state_t;

  state_t state_r;

  entry_t mem [MAX_PROCS];
  entry_t rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;

  logic [1:0]       op_r;
  logic [15:0]      id_in_r, arr_in_r, burst_in_r;
  logic [7:0]       prio_in_r;
  logic [RND_W-1:0] rnd_r;

  logic [CNT_W-1:0] cnt_r, fin_r, i_r, j_r, t_r, s_r;
  logic             pass_r;
  logic             ordered_r;
  logic [MAX_PROCS-1:0] started_r, done_r;
  logic [TKT_W-1:0] tot_r, low_r, rem_r;
  logic [RND_W-1:0] dvd_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [CLK_W-1:0] clk_r;
  logic [24:0]      sum_wait_r, sum_turn_r;
  logic [23:0]      sum_resp_r;
  entry_t           a_r, b_r, rec_r;
  logic [IDX_W-1:0] k_r;

  logic [2:0]       res_ev_r;
  logic [15:0]      res_win_r;
  logic [CLK_W-1:0] res_resp_r;
  logic [20:0]      res_wait_r, res_turn_r;

  logic                          out_tvalid_r;
  logic [OUT_DATA_W-1:0]         out_tdata_r;
  logic [OUT_USER_W-1:0]         out_tuser_r;

  logic [CNT_W-1:0] jm1, lb;
  logic             swap;
  logic [TKT_W-1:0] low_nx;
  logic [TKT_W:0]   rem_sh, rem_nx;
  logic [TKT_W-1:0] diff;
  logic             hit;
  logic             cur_started, cur_done, run;
  logic [20:0]      turn_w, wait_w;
  entry_t           load_rec, tkt_rec, run_rec;

  always_comb begin
    jm1    = j_r - CNT_W'(1);
    lb     = pass_r ? CNT_W'(1) : CNT_W'(0);
    swap   = pass_r ? (a_r.prio > rd_q.prio) : (a_r.arrival > rd_q.arrival);
    low_nx = low_r + TKT_W'(rd_q.burst) + TKT_W'(1);
    rem_sh = {rem_r, dvd_r[RND_W-1]};
    rem_nx = (rem_sh >= {1'b0, tot_r}) ? rem_sh - {1'b0, tot_r} : rem_sh;
    diff   = rem_r - rd_q.tlow;
    hit    = (rem_r >= rd_q.tlow) && (diff <= TKT_W'(rd_q.burst));
    cur_started = started_r[k_r];
    cur_done    = done_r[k_r];
    run         = rec_r.remaining != 16'd0;
    turn_w = {1'b0, clk_r} - {5'd0, rec_r.arrival};
    wait_w = turn_w - {5'd0, rec_r.burst};

    load_rec           = '0;
    load_rec.id        = id_in_r;
    load_rec.arrival   = arr_in_r;
    load_rec.prio      = prio_in_r;
    load_rec.burst     = burst_in_r;
    load_rec.remaining = burst_in_r;

    tkt_rec      = rd_q;
    tkt_rec.tlow = low_r;

    run_rec           = rec_r;
    run_rec.remaining = rec_r.remaining - 16'd1;
    run_rec.resp      = cur_started ? rec_r.resp : clk_r;
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = load_rec;
    mem_raddr = '0;
    case (state_r)
      S_OP: begin
        mem_we    = (op_r == OP_LOAD) && !ordered_r && (cnt_r < CNT_W'(MAX_PROCS));
        mem_waddr = cnt_r[IDX_W-1:0];
      end
      S_SRA:  mem_raddr = jm1[IDX_W-1:0];
      S_SRB:  mem_raddr = j_r[IDX_W-1:0];
      S_SWA: begin
        mem_we    = 1'b1;
        mem_waddr = jm1[IDX_W-1:0];
        mem_wdata = b_r;
      end
      S_SWB: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IDX_W-1:0];
        mem_wdata = a_r;
      end
      S_TRD:  mem_raddr = t_r[IDX_W-1:0];
      S_TWR: begin
        mem_we    = 1'b1;
        mem_waddr = t_r[IDX_W-1:0];
        mem_wdata = tkt_rec;
      end
      S_QRD:  mem_raddr = s_r[IDX_W-1:0];
      S_APPLY: begin
        mem_we    = !cur_done && run;
        mem_waddr = k_r;
        mem_wdata = run_rec;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      fin_r        <= '0;
      ordered_r    <= 1'b0;
      tot_r        <= '0;
      clk_r        <= '0;
      sum_wait_r   <= '0;
      sum_turn_r   <= '0;
      sum_resp_r   <= '0;
      started_r    <= '0;
      done_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_tuser;
            id_in_r    <= in_tdata[15:0];
            arr_in_r   <= in_tdata[31:16];
            prio_in_r  <= in_tdata[39:32];
            burst_in_r <= in_tdata[55:40];
            rnd_r      <= in_tdata[86:56];
            state_r    <= S_OP;
          end
        end
        S_OP: begin
          res_resp_r <= '0;
          res_wait_r <= '0;
          res_turn_r <= '0;
          case (op_r)
            OP_CLEAR: begin
              cnt_r      <= '0;
              fin_r      <= '0;
              ordered_r  <= 1'b0;
              tot_r      <= '0;
              clk_r      <= '0;
              sum_wait_r <= '0;
              sum_turn_r <= '0;
              sum_resp_r <= '0;
              started_r  <= '0;
              done_r     <= '0;
              res_ev_r   <= EV_CLEARED;
              res_win_r  <= '0;
              state_r    <= S_EMIT;
            end
            OP_LOAD: begin
              state_r <= S_EMIT;
              if (!ordered_r && (cnt_r < CNT_W'(MAX_PROCS))) begin
                started_r[cnt_r[IDX_W-1:0]] <= 1'b0;
                done_r[cnt_r[IDX_W-1:0]]    <= 1'b0;
                cnt_r     <= cnt_r + CNT_W'(1);
                res_ev_r  <= EV_LOADED;
                res_win_r <= id_in_r;
              end else begin
                res_ev_r  <= EV_NONE;
                res_win_r <= '0;
              end
            end
            OP_DRAW: begin
              res_ev_r  <= EV_NONE;
              res_win_r <= '0;
              if (cnt_r != '0) begin
                if (!ordered_r) begin
                  pass_r  <= 1'b0;
                  i_r     <= CNT_W'(1);
                  state_r <= S_SNEXT;
                end else begin
                  rem_r   <= '0;
                  dvd_r   <= rnd_r;
                  dcnt_r  <= DCNT_W'(RND_W - 1);
                  state_r <= S_DIV;
                end
              end else begin
                state_r <= S_EMIT;
              end
            end
            default: begin
              res_ev_r  <= EV_NONE;
              res_win_r <= '0;
              state_r   <= S_EMIT;
            end
          endcase
        end
        S_SNEXT: begin
          if (i_r >= cnt_r) begin
            if (!pass_r) begin
              pass_r <= 1'b1;
              i_r    <= CNT_W'(2);
            end else begin
              t_r     <= '0;
              low_r   <= '0;
              state_r <= S_TRD;
            end
          end else begin
            j_r     <= i_r;
            state_r <= S_SRA;
          end
        end
        S_SRA: state_r <= S_SRB;
        S_SRB: begin
          a_r     <= rd_q;
          state_r <= S_SCMP;
        end
        S_SCMP: begin
          b_r <= rd_q;
          if (swap) begin
            state_r <= S_SWA;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_SNEXT;
          end
        end
        S_SWA: state_r <= S_SWB;
        S_SWB: begin
          // keep walking the new entry down while it sits above the bound
          if (j_r > lb + CNT_W'(1)) begin
            j_r     <= jm1;
            state_r <= S_SRA;
          end else begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_SNEXT;
          end
        end
        S_TRD: state_r <= S_TWR;
        S_TWR: begin
          low_r <= low_nx;
          t_r   <= t_r + CNT_W'(1);
          if (t_r + CNT_W'(1) == cnt_r) begin
            tot_r     <= low_nx;
            ordered_r <= 1'b1;
            rem_r     <= '0;
            dvd_r     <= rnd_r;
            dcnt_r    <= DCNT_W'(RND_W - 1);
            state_r   <= S_DIV;
          end else begin
            state_r <= S_TRD;
          end
        end
        S_DIV: begin
          // restoring remainder, one dividend bit per cycle
          rem_r <= rem_nx[TKT_W-1:0];
          dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
          if (dcnt_r == '0) begin
            s_r     <= '0;
            state_r <= S_QRD;
          end else begin
            dcnt_r <= dcnt_r - DCNT_W'(1);
          end
        end
        S_QRD: state_r <= S_QCHK;
        S_QCHK: begin
          if (hit) begin
            rec_r   <= rd_q;
            k_r     <= s_r[IDX_W-1:0];
            state_r <= S_APPLY;
          end else if (s_r + CNT_W'(1) == cnt_r) begin
            state_r <= S_EMIT;
          end else begin
            s_r     <= s_r + CNT_W'(1);
            state_r <= S_QRD;
          end
        end
        S_APPLY: begin
          res_win_r <= rec_r.id;
          state_r   <= S_EMIT;
          if (cur_done) begin
            res_ev_r <= EV_NONE;
          end else if (run) begin
            started_r[k_r] <= 1'b1;
            if (!cur_started) begin
              sum_resp_r <= sum_resp_r + {4'd0, clk_r};
            end
            if (clk_r != CLOCK_MAX) begin
              clk_r <= clk_r + CLK_W'(1);
            end
            res_resp_r <= run_rec.resp;
            res_ev_r   <= EV_RAN;
          end else begin
            done_r[k_r] <= 1'b1;
            res_turn_r  <= turn_w;
            res_wait_r  <= wait_w;
            sum_wait_r  <= sum_wait_r + {{4{wait_w[20]}}, wait_w};
            sum_turn_r  <= sum_turn_r + {{4{turn_w[20]}}, turn_w};
            fin_r       <= fin_r + CNT_W'(1);
            res_resp_r  <= cur_started ? rec_r.resp : '0;
            res_ev_r    <= EV_COMPLETED;
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= res_ev_r;
            out_tdata_r  <= {3'd0, sum_resp_r, sum_turn_r, sum_wait_r,
                             (cnt_r != '0) && (fin_r == cnt_r),
                             res_turn_r, res_wait_r, res_resp_r, clk_r, res_win_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `CHK_SAME(a_fin_le_cnt, clk, rst_n, 1'b1, fin_r <= cnt_r)
  `CHK_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `CHK_SAME(a_ordered_tickets, clk, rst_n, ordered_r, tot_r != '0)
  `CHK_SAME(a_apply_ordered, clk, rst_n, state_r == S_APPLY, ordered_r)

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lottery cpu scheduler: a directed table, then
// random batches of clear, load, draw and bad-op items, checked by a predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcs_pkg::*;

  localparam int  N_ITEMS = 1600;
  localparam int  QUIET_AT = 1400;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_BAD = 2'd3;

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] win;
    logic [19:0] tnow;
    logic [19:0] resp;
    logic [20:0] wt;
    logic [20:0] turn;
    logic        done;
    logic [24:0] swt;
    logic [24:0] sturn;
    logic [23:0] sresp;
  } sched_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] id;
    logic [15:0] arr;
    logic [7:0]  pri;
    logic [15:0] bur;
    logic [30:0] rnd;
    bit          typed;
    logic [2:0]  ev;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  always #2 clk = ~clk;

  lottery_cpu_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // predictor copy of the process table
  logic [15:0] p_id  [MAX_PROCS];
  logic [15:0] p_arr [MAX_PROCS];
  logic [7:0]  p_pri [MAX_PROCS];
  logic [15:0] p_bur [MAX_PROCS];
  logic [15:0] p_rem [MAX_PROCS];
  logic [20:0] p_tlo [MAX_PROCS];
  logic [19:0] p_rsp [MAX_PROCS];
  bit          p_run [MAX_PROCS];
  bit          p_fin [MAX_PROCS];
  int          n_procs, n_fin;
  bit          sorted;
  logic [20:0] tickets;
  logic [19:0] sched_clk;
  logic [24:0] sum_wt, sum_turn;
  logic [23:0] sum_resp;

  sched_res_t expected_q[$];
  int  n_sent = 0;
  int  n_bad = 0;
  bit  quiet = 1'b0;
  longint cycles = 0;

  task automatic clear_table();
    for (int i = 0; i < MAX_PROCS; i++) begin
      p_run[i] = 0;
      p_fin[i] = 0;
    end
    n_procs = 0; n_fin = 0; sorted = 0; tickets = '0;
    sched_clk = '0; sum_wt = '0; sum_turn = '0; sum_resp = '0;
  endtask

  task automatic swap_slots(input int a, input int b);
    logic [15:0] t16;
    logic [7:0]  t8;
    t16 = p_id[a];  p_id[a]  = p_id[b];  p_id[b]  = t16;
    t16 = p_arr[a]; p_arr[a] = p_arr[b]; p_arr[b] = t16;
    t8  = p_pri[a]; p_pri[a] = p_pri[b]; p_pri[b] = t8;
    t16 = p_bur[a]; p_bur[a] = p_bur[b]; p_bur[b] = t16;
    t16 = p_rem[a]; p_rem[a] = p_rem[b]; p_rem[b] = t16;
  endtask

  task automatic sort_and_deal();
    logic [20:0] low;
    low = '0;
    for (int i = 1; i < n_procs; i++)
      for (int j = i; j > 0 && p_arr[j-1] > p_arr[j]; j--) swap_slots(j - 1, j);
    // the head entry keeps its place in the priority pass
    for (int i = 2; i < n_procs; i++)
      for (int j = i; j > 1 && p_pri[j-1] > p_pri[j]; j--) swap_slots(j - 1, j);
    for (int i = 0; i < n_procs; i++) begin
      p_tlo[i] = low;
      low = low + 21'(p_bur[i]) + 21'd1;
    end
    tickets = low;
    sorted = 1;
  endtask

  task automatic predict_item(input logic [IN_DATA_W-1:0] d, input logic [1:0] op,
                              output sched_res_t r);
    int unsigned tk;
    int k;
    logic [31:0] turn32;
    r = '0;
    r.ev = EV_NONE;
    if (op == OP_CLEAR) begin
      clear_table();
      r.ev = EV_CLEARED;
    end else if (op == OP_LOAD) begin
      if (!sorted && n_procs < MAX_PROCS) begin
        p_id[n_procs]  = d[15:0];
        p_arr[n_procs] = d[31:16];
        p_pri[n_procs] = d[39:32];
        p_bur[n_procs] = d[55:40];
        p_rem[n_procs] = d[55:40];
        p_rsp[n_procs] = '0;
        p_run[n_procs] = 0;
        p_fin[n_procs] = 0;
        r.win = d[15:0];
        n_procs++;
        r.ev = EV_LOADED;
      end
    end else if (op == OP_DRAW && n_procs > 0) begin
      if (!sorted) sort_and_deal();
      tk = (tickets != 0) ? 32'(d[86:56]) % 32'(tickets) : 0;
      k = -1;
      for (int j = 0; j < n_procs && k < 0; j++)
        if (tk >= p_tlo[j] && tk - p_tlo[j] <= p_bur[j]) k = j;
      if (k >= 0) begin
        r.win = p_id[k];
        if (p_fin[k]) begin
          r.ev = EV_NONE;
        end else if (p_rem[k] > 0) begin
          p_rem[k]--;
          if (!p_run[k]) begin
            p_run[k] = 1;
            p_rsp[k] = sched_clk;
            sum_resp = sum_resp + 24'(sched_clk);
          end
          if (sched_clk != CLOCK_MAX) sched_clk++;
          r.resp = p_rsp[k];
          r.ev = EV_RAN;
        end else begin
          p_fin[k] = 1;
          turn32 = 32'(sched_clk) - 32'(p_arr[k]);
          r.turn = turn32[20:0];
          r.wt = 21'(turn32 - 32'(p_bur[k]));
          sum_wt = sum_wt + 25'($signed(r.wt));
          sum_turn = sum_turn + 25'($signed(r.turn));
          n_fin++;
          r.resp = p_run[k] ? p_rsp[k] : '0;
          r.ev = EV_COMPLETED;
        end
      end
    end
    r.tnow = sched_clk;
    r.done = (n_procs > 0 && n_fin == n_procs);
    r.swt = sum_wt;
    r.sturn = sum_turn;
    r.sresp = sum_resp;
  endtask

  task automatic report_bad(input sched_res_t exp_r, input sched_res_t got_r);
    n_bad++;
    if (n_bad <= 10) $display("mismatch: expected %p got %p", exp_r, got_r);
  endtask

  // one transfer; valid stays high across back-to-back items
  task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                           input logic [15:0] arr, input logic [7:0] pri,
                           input logic [15:0] bur, input logic [30:0] rnd,
                           input bit typed, input logic [2:0] ev);
    logic [IN_DATA_W-1:0] d;
    sched_res_t r;
    d = '0;
    d[15:0] = id; d[31:16] = arr; d[39:32] = pri; d[55:40] = bur; d[86:56] = rnd;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    predict_item(d, op, r);
    if (typed && r.ev != ev) begin
      sched_res_t t;
      t = r;
      t.ev = ev;
      report_bad(t, r);
    end
    expected_q.push_back(r);
    n_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic load_rand(input bit small_burst);
    logic [15:0] b;
    b = small_burst ? 16'($urandom_range(0, 6)) : 16'($urandom);
    send_item(OP_LOAD, 16'($urandom), 16'($urandom_range(0, 40)), 8'($urandom), b,
              31'($urandom), 0, '0);
  endtask

  // one scheduling run: clear, fill, then draw towards completion, with stray loads and bad ops mixed in
  task automatic run_batch();
    int n, draws;
    bit wide;
    send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
              31'($urandom), 0, '0);
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
    wide = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if (wide && $urandom_range(0, 1)) begin
        send_item(OP_LOAD, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                  31'($urandom), 0, '0);
      end else begin
        load_rand(1);
      end
    end
    draws = $urandom_range(10, 70);
    for (int i = 0; i < draws && n_sent < N_ITEMS; i++) begin
      case ($urandom_range(0, 19))
        0: load_rand(0);
        1: send_item(OP_BAD, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                     31'($urandom), 0, '0);
        default: send_item(OP_DRAW, 16'($urandom), 16'($urandom), 8'($urandom),
                           16'($urandom), 31'($urandom), 0, '0);
      endcase
      if (n_procs > 0 && n_fin == n_procs && $urandom_range(0, 2) == 0) break;
    end
  endtask

  // result side
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || stall_left == 0) begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 9);
    end else begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    sched_res_t got_r, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_r.ev    = out_tuser;
      got_r.win   = out_tdata[15:0];
      got_r.tnow  = out_tdata[35:16];
      got_r.resp  = out_tdata[55:36];
      got_r.wt    = out_tdata[76:56];
      got_r.turn  = out_tdata[97:77];
      got_r.done  = out_tdata[98];
      got_r.swt   = out_tdata[123:99];
      got_r.sturn = out_tdata[148:124];
      got_r.sresp = out_tdata[172:149];
      if (expected_q.size() == 0) begin
        report_bad('0, got_r);
      end else begin
        exp_r = expected_q.pop_front();
        if (got_r.ev != exp_r.ev || got_r.win != exp_r.win || got_r.tnow != exp_r.tnow ||
            got_r.resp != exp_r.resp || got_r.wt != exp_r.wt ||
            got_r.turn != exp_r.turn || got_r.done != exp_r.done ||
            got_r.swt != exp_r.swt || got_r.sturn != exp_r.sturn ||
            got_r.sresp != exp_r.sresp)
          report_bad(exp_r, got_r);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  stim_row_t rows[$];

  initial begin
    clear_table();
    for (int i = 0; i < MAX_PROCS; i++) begin
      p_id[i] = '0; p_arr[i] = '0; p_pri[i] = '0; p_bur[i] = '0;
      p_rem[i] = '0; p_tlo[i] = '0; p_rsp[i] = '0;
    end
    rows = '{
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h7fffffff, 1, EV_NONE},
      '{OP_BAD,   16'hffff, 16'hffff, 8'hff, 16'hffff, 31'h7fffffff, 1, EV_NONE},
      '{OP_CLEAR, 16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000000, 1, EV_CLEARED},
      '{OP_LOAD,  16'hffff, 16'hffff, 8'hff, 16'h0000, 31'h00000000, 1, EV_LOADED},
      '{OP_LOAD,  16'h0000, 16'h0000, 8'h00, 16'h0001, 31'h00000000, 1, EV_LOADED},
      '{OP_LOAD,  16'h1234, 16'h0005, 8'h00, 16'h0002, 31'h00000000, 1, EV_LOADED},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h7fffffff, 0, EV_NONE},
      '{OP_LOAD,  16'h5555, 16'h0001, 8'h01, 16'h0001, 31'h00000000, 1, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000000, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000001, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000002, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000003, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000004, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000005, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000006, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000000, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h55555555, 0, EV_NONE},
      '{OP_CLEAR, 16'hffff, 16'hffff, 8'hff, 16'hffff, 31'h7fffffff, 1, EV_CLEARED},
      '{OP_LOAD,  16'haaaa, 16'h8000, 8'h80, 16'hffff, 31'h00000000, 1, EV_LOADED},
      '{OP_LOAD,  16'h0001, 16'h0000, 8'hff, 16'h0000, 31'h00000000, 1, EV_LOADED},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00010000, 0, EV_NONE},
      '{OP_DRAW,  16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h2aaaaaaa, 0, EV_NONE},
      '{OP_CLEAR, 16'h0000, 16'h0000, 8'h00, 16'h0000, 31'h00000000, 1, EV_CLEARED}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send_item(rows[i].op, rows[i].id, rows[i].arr, rows[i].pri, rows[i].bur,
                rows[i].rnd, rows[i].typed, rows[i].ev);
    while (n_sent < N_ITEMS) begin
      if (n_sent >= QUIET_AT) quiet = 1'b1;
      run_batch();
    end
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_bad == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
